@@ rtl/tgrc_pkg.sv @@
package tgrc_pkg;

   localparam int DIV_W = 17;
   localparam int DEN_W = 8;

   localparam logic [2:0] CSR_CELL_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_CELL_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_GRID_COLS    = 3'd2;
   localparam logic [2:0] CSR_GRID_ROWS    = 3'd3;
   localparam logic [2:0] CSR_PIXEL_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_PIXEL_HEIGHT = 3'd5;

   localparam logic OP_MARK  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/tile_grid_rect_collision.sv @@
// Tile grid rectangle collision. Requests on req_* either mark one grid cell
// blocked (tuser = 0) or query a pixel rectangle (tuser = 1); each request
// gives exactly one response on rsp_*, collides in bit 0 (always 0 for a
// mark). The grid is kept as MAX_ROWS rows of MAX_COLS bits in a RAM with a
// per-row valid bit, so it reads as clear right after reset with no clearing
// pass. One request is worked at a time. A mark is a read-modify-write of
// its row: a read state, a write state, then the done state that answers.
// A mark that leaves the cell as it is, and a query that fails the border
// test, go straight to the done state. Otherwise one shared 17-step divider
// runs four times for the column and row limits, then the covered rows are
// scanned one at a time through the RAM read port, a read state and then a
// check state per row, stopping at the first hit. A waiting response holds
// the next one back. csr_* writes are taken in any cycle but belong in idle
// time only.
module tile_grid_rect_collision #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cell_col[5:0] cell_row[11:6] cell_value[19:12] rect_left[35:20]
   // rect_top[51:36] rect_width[66:52] rect_height[81:67] allow_outside[82]
   input  logic [87:0] req_tdata,
   // operation[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // collides[0]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import tgrc_pkg::*;

   localparam int RAW = $clog2(MAX_ROWS);
   localparam int CW  = $clog2(MAX_COLS + 1);
   localparam int RCW = $clog2(MAX_ROWS + 1);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DSTART = 9'b000000010,
      S_DIV    = 9'b000000100,
      S_SETUP  = 9'b000001000,
      S_RD     = 9'b000010000,
      S_CHK    = 9'b000100000,
      S_MRD    = 9'b001000000,
      S_MWR    = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]  cell_width_ff, cell_height_ff;
   logic [6:0]  grid_cols_ff, grid_rows_ff;
   logic [15:0] pixel_width_ff, pixel_height_ff;

   logic [5:0]         in_col, in_row;
   logic signed [7:0]  in_value;
   logic signed [15:0] in_left, in_top;
   logic [14:0]        in_w, in_h;
   logic               in_allow;
   logic signed [17:0] in_stop_x, in_stop_y;
   logic               border_hit, mark_ok;

   logic signed [15:0] left_ff, left_in, top_ff, top_in;
   logic [14:0]        w_ff, w_in, h_ff, h_in;
   logic [5:0]         col_ff, col_in;
   logic [RCW-1:0]     row_ff, row_in;
   logic [RCW-1:0]     y1_ff, y1_in;
   logic [1:0]         sel_ff, sel_in;
   logic [3:0][DIV_W-1:0] quo_ff, quo_in;
   logic [MAX_COLS-1:0] mask_ff, mask_in;
   logic               res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_data_ff, rsp_data_in;
   logic [MAX_ROWS-1:0] row_valid_ff, row_valid_in;
   logic               rvalid_ff;

   logic [DEN_W-1:0]   cx, cy, den;
   logic signed [17:0] stop_x, stop_y, start_s, stop_s;
   logic signed [17:0] end_sum;
   logic [DIV_W-1:0]   dividend;

   logic [CW-1:0]      cols_lim, x0, x1;
   logic [RCW-1:0]     rows_lim, y0, y1;
   logic               empty;
   logic [RCW-1:0]     row_next;
   logic               hit;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                ram_wr_en;
   logic [MAX_COLS-1:0] ram_rd_data, ram_wr_data, col_bit;

   // request fields
   assign in_col    = req_tdata[5:0];
   assign in_row    = req_tdata[11:6];
   assign in_value  = req_tdata[19:12];
   assign in_left   = req_tdata[35:20];
   assign in_top    = req_tdata[51:36];
   assign in_w      = req_tdata[66:52];
   assign in_h      = req_tdata[81:67];
   assign in_allow  = req_tdata[82];
   assign in_stop_x = 18'(in_left) + $signed({3'b0, in_w});
   assign in_stop_y = 18'(in_top) + $signed({3'b0, in_h});

   assign border_hit = !in_allow && (in_left < 0 || in_top < 0 ||
                       in_stop_x > $signed({2'b0, pixel_width_ff}) ||
                       in_stop_y > $signed({2'b0, pixel_height_ff}));
   assign mark_ok = (in_value > 0) && (32'(in_col) < 32'(MAX_COLS)) &&
                    (32'(in_row) < 32'(MAX_ROWS));

   // divider operand for the current axis limit
   assign cx     = (cell_width_ff == '0) ? DEN_W'(1) : cell_width_ff;
   assign cy     = (cell_height_ff == '0) ? DEN_W'(1) : cell_height_ff;
   assign den    = sel_ff[1] ? cy : cx;
   assign stop_x = 18'(left_ff) + $signed({3'b0, w_ff});
   assign stop_y = 18'(top_ff) + $signed({3'b0, h_ff});
   assign start_s = sel_ff[1] ? 18'(top_ff) : 18'(left_ff);
   assign stop_s  = sel_ff[1] ? stop_y : stop_x;
   assign end_sum = stop_s + $signed({10'b0, den}) - 18'sd1;

   always_comb begin
      if (!sel_ff[0]) begin
         dividend = (start_s > 0) ? DIV_W'(start_s) : '0;
      end else begin
         dividend = (stop_s > 0) ? DIV_W'(end_sum) : '0;
      end
   end

   assign div_req.start    = (state_ff == S_DSTART);
   assign div_req.dividend = dividend;
   assign div_req.divisor  = den;

   tgrc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // cell range
   assign cols_lim = (32'(grid_cols_ff) > MAX_COLS) ? CW'(MAX_COLS) : CW'(grid_cols_ff);
   assign rows_lim = (32'(grid_rows_ff) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(grid_rows_ff);
   assign x1 = (quo_ff[1] > DIV_W'(cols_lim)) ? cols_lim : CW'(quo_ff[1]);
   assign y1 = (quo_ff[3] > DIV_W'(rows_lim)) ? rows_lim : RCW'(quo_ff[3]);
   assign x0 = CW'(quo_ff[0]);
   assign y0 = RCW'(quo_ff[2]);
   assign empty = (quo_ff[0] >= DIV_W'(x1)) || (quo_ff[2] >= DIV_W'(y1));

   always_comb begin
      for (int i = 0; i < MAX_COLS; i++) begin
         mask_in[i] = (CW'(i) >= x0) && (CW'(i) < x1);
         col_bit[i] = (32'(col_ff) == i);
      end
   end

   assign row_next = row_ff + RCW'(1);
   assign hit      = rvalid_ff && (|(ram_rd_data & mask_ff));

   assign ram_wr_en   = (state_ff == S_MWR);
   assign ram_wr_data = (rvalid_ff ? ram_rd_data : '0) | col_bit;

   tgrc_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (row_ff[RAW-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (row_ff[RAW-1:0]),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      top_in       = top_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      y1_in        = y1_ff;
      sel_in       = sel_ff;
      quo_in       = quo_ff;
      res_in       = res_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               left_in = in_left;
               top_in  = in_top;
               w_in    = in_w;
               h_in    = in_h;
               col_in  = in_col;
               row_in  = RCW'(in_row);
               sel_in  = '0;
               res_in  = 1'b0;
               if (req_tuser == OP_MARK) begin
                  state_in = mark_ok ? S_MRD : S_DONE;
               end else if (border_hit) begin
                  res_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_DSTART;
               end
            end
         end
         S_DSTART: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               quo_in[sel_ff] = div_rsp.quotient;
               sel_in         = sel_ff + 2'd1;
               state_in       = (sel_ff == 2'd3) ? S_SETUP : S_DSTART;
            end
         end
         S_SETUP: begin
            y1_in  = y1;
            row_in = y0;
            if (empty) begin
               state_in = S_DONE;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (hit) begin
               res_in   = 1'b1;
               state_in = S_DONE;
            end else if (row_next >= y1_ff) begin
               state_in = S_DONE;
            end else begin
               row_in   = row_next;
               state_in = S_RD;
            end
         end
         S_MRD: begin
            state_in = S_MWR;
         end
         S_MWR: begin
            row_valid_in[row_ff[RAW-1:0]] = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         row_valid_ff    <= '0;
         cell_width_ff   <= 8'd8;
         cell_height_ff  <= 8'd8;
         grid_cols_ff    <= 7'd64;
         grid_rows_ff    <= 7'd64;
         pixel_width_ff  <= 16'd512;
         pixel_height_ff <= 16'd512;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_CELL_WIDTH:   cell_width_ff   <= csr_data[7:0];
               CSR_CELL_HEIGHT:  cell_height_ff  <= csr_data[7:0];
               CSR_GRID_COLS:    grid_cols_ff    <= csr_data[6:0];
               CSR_GRID_ROWS:    grid_rows_ff    <= csr_data[6:0];
               CSR_PIXEL_WIDTH:  pixel_width_ff  <= csr_data;
               CSR_PIXEL_HEIGHT: pixel_height_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      top_ff      <= top_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      y1_ff       <= y1_in;
      sel_ff      <= sel_in;
      quo_ff      <= quo_in;
      mask_ff     <= (state_ff == S_SETUP) ? mask_in : mask_ff;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rvalid_ff   <= row_valid_ff[row_ff[RAW-1:0]];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff};

`ifndef NO_ASSERTIONS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished outside a division step");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) |-> (row_ff < y1_ff))
      else $error("row scan past end of range");
`endif

endmodule

@@ rtl/tgrc_ram.sv @@
module tgrc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tgrc_div.sv @@
module tgrc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tgrc_pkg::div_req_type div_req,
   output tgrc_pkg::div_rsp_type div_rsp
);
   import tgrc_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         num_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_in = {num_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

endmodule
